// ===== src/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the 2-D k-means block: field widths, input
// actions, result status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package kmc_pkg;

  // Field widths fixed by the stream format
  localparam int COORD_W = 16;
  localparam int NUM_CL = 4;
  localparam int CL_W = 2;
  localparam int SIZE_W = 11;
  localparam int ITER_W = 16;
  localparam int STAT_W = 2;
  localparam int ACT_W = 2;
  localparam int BC_W = $clog2(COORD_W + 1);

  localparam int IN_TDATA_W = 2 * COORD_W;
  localparam int OUT_FIELDS_W = CL_W + 2 * COORD_W + SIZE_W + ITER_W;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int MAX_POINTS_DEF = 1024;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST = ITER_W'(1000);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_RUN   = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_LIMIT     = 2'd1,
    STAT_FEW       = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PASS_START,
    ST_PASS,
    ST_CHECK,
    ST_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    load_wr;
    logic    run_start;
    logic    seed;
    logic    pass_init;
    logic    pass_run;
    logic    div_init;
    logic    div_run;
    logic    res_init;
    logic    emit;
    logic    out_flag;
    status_t flag_code;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic full;
    logic few;
    logic seed_done;
    logic pass_done;
    logic changed;
    logic limit_hit;
    logic div_done;
    logic res_done;
  } sts_t;

endpackage

// ===== src/kmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmc_ctrl
// Sequencer of the k-means block: takes input transfers, then steps a run
// through seeding, assignment passes, center updates and result output.
// ----------------------------------------------------------------------------
module kmc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [kmc_pkg::ACT_W-1:0] s_axis_tuser,
  input  kmc_pkg::sts_t             sts,
  output kmc_pkg::cmd_t             cmd
);

  kmc_pkg::state_t state, state_next;
  kmc_pkg::action_t act;
  logic accept;

  assign act = kmc_pkg::action_t'(s_axis_tuser);
  assign s_axis_tready = (state == kmc_pkg::ST_IDLE) && !sts.out_busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      kmc_pkg::ST_IDLE: begin
        if (accept && act == kmc_pkg::ACT_RUN && !sts.few) begin
          state_next = kmc_pkg::ST_SEED;
        end
      end
      kmc_pkg::ST_SEED: begin
        if (sts.seed_done) begin
          state_next = kmc_pkg::ST_PASS_START;
        end
      end
      kmc_pkg::ST_PASS_START: state_next = kmc_pkg::ST_PASS;
      kmc_pkg::ST_PASS: begin
        if (sts.pass_done) begin
          state_next = kmc_pkg::ST_CHECK;
        end
      end
      kmc_pkg::ST_CHECK: begin
        if (sts.changed && !sts.limit_hit) begin
          state_next = kmc_pkg::ST_DIV;
        end else begin
          state_next = kmc_pkg::ST_RESULT;
        end
      end
      kmc_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_next = kmc_pkg::ST_PASS_START;
        end
      end
      kmc_pkg::ST_RESULT: begin
        if (sts.res_done) begin
          state_next = kmc_pkg::ST_IDLE;
        end
      end
      default: state_next = kmc_pkg::ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd = '0;
    cmd.flag_code = kmc_pkg::STAT_CONVERGED;
    case (state)
      kmc_pkg::ST_IDLE: begin
        if (accept) begin
          case (act)
            kmc_pkg::ACT_CLEAR: cmd.clear = 1'b1;
            kmc_pkg::ACT_LOAD: begin
              if (sts.full) begin
                cmd.out_flag = 1'b1;
                cmd.flag_code = kmc_pkg::STAT_FULL;
              end else begin
                cmd.load_wr = 1'b1;
              end
            end
            kmc_pkg::ACT_RUN: begin
              if (sts.few) begin
                cmd.out_flag = 1'b1;
                cmd.flag_code = kmc_pkg::STAT_FEW;
              end else begin
                cmd.run_start = 1'b1;
              end
            end
            default: cmd.clear = 1'b0;
          endcase
        end
      end
      kmc_pkg::ST_SEED: cmd.seed = 1'b1;
      kmc_pkg::ST_PASS_START: cmd.pass_init = 1'b1;
      kmc_pkg::ST_PASS: cmd.pass_run = 1'b1;
      kmc_pkg::ST_CHECK: begin
        if (sts.changed && !sts.limit_hit) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.res_init = 1'b1;
        end
      end
      kmc_pkg::ST_DIV: cmd.div_run = 1'b1;
      kmc_pkg::ST_RESULT: cmd.emit = 1'b1;
      default: cmd.clear = 1'b0;
    endcase
  end

endmodule

// ===== src/kmc_datapath.sv =====
// ----------------------------------------------------------------------------
// kmc_datapath
// Point store, assignment store, distance pipeline, cluster accumulators,
// bit-serial center divider, iteration counter and output register.
// ----------------------------------------------------------------------------
module kmc_datapath #(
  parameter int MAX_POINTS = kmc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kmc_pkg::cmd_t                   cmd,
  output kmc_pkg::sts_t                   sts,
  input  logic [kmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            cfg_wr_en,
  input  logic [kmc_pkg::ITER_W-1:0]      cfg_wr_data,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [kmc_pkg::STAT_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int C = kmc_pkg::COORD_W;
  localparam int K = kmc_pkg::NUM_CL;
  localparam int CW = kmc_pkg::CL_W;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = C + IDX_W;
  localparam int SQ_W = 2 * C;
  localparam int D_W = 2 * C + 1;

  // Stores
  logic [2*C-1:0] pmem [MAX_POINTS];
  logic [CW-1:0] amem [MAX_POINTS];

  logic [CNT_W-1:0] pc;
  logic [CNT_W-1:0] iss;
  logic issuing;
  logic [2*C-1:0] rd_pt;
  logic [CW-1:0] rd_as;
  logic rd_seed, rd_pass;
  logic [CNT_W-1:0] rd_idx;

  // Cluster state
  logic [C-1:0] cx [K];
  logic [C-1:0] cy [K];
  logic [CNT_W-1:0] cnt [K];
  logic [SUM_W-1:0] sx [K];
  logic [SUM_W-1:0] sy [K];
  logic [CW-1:0] cl_sel;
  logic [CNT_W-1:0] sel_cnt;
  logic [SUM_W-1:0] sel_sx, sel_sy;

  // Distance pipeline
  logic a_v, b_v, c_v, d_v, e_v;
  logic [IDX_W-1:0] a_idx, b_idx, c_idx, d_idx, e_idx;
  logic [C-1:0] a_px, b_px, c_px, d_px, e_px;
  logic [C-1:0] a_py, b_py, c_py, d_py, e_py;
  logic [CW-1:0] a_old, b_old, c_old, d_old, e_old;
  logic [C-1:0] a_dx [K];
  logic [C-1:0] a_dy [K];
  logic [SQ_W-1:0] b_sx [K];
  logic [SQ_W-1:0] b_sy [K];
  logic [D_W-1:0] c_d [K];
  logic [CW-1:0] d_w01, d_w23, e_best;
  logic [D_W-1:0] d_d01, d_d23;
  logic changed, first_pass;

  // Divider
  logic [CW:0] jb;
  logic [kmc_pkg::BC_W-1:0] bc;
  logic [CNT_W-1:0] rem;
  logic [C-1:0] q;
  logic [SUM_W-1:0] div_sum;
  logic [CNT_W:0] trial;
  logic qbit;
  logic [CNT_W-1:0] rem_next;
  logic div_adv;

  // Iterations, limit, output
  logic [kmc_pkg::ITER_W-1:0] iters, limit;
  logic [CW-1:0] oj;
  logic out_free;
  logic [CW-1:0] o_idx;
  logic [C-1:0] o_cx, o_cy;
  logic [kmc_pkg::SIZE_W-1:0] o_size;
  logic [kmc_pkg::ITER_W-1:0] o_iter;
  logic [kmc_pkg::STAT_W-1:0] o_stat;
  logic o_last;

  // Point count and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      limit <= kmc_pkg::ITER_LIMIT_RST;
    end else begin
      if (cmd.clear) begin
        pc <= '0;
      end else if (cmd.load_wr) begin
        pc <= pc + CNT_W'(1);
      end
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
    end
  end

  // Issue reads for seeding or a pass
  assign issuing = (cmd.seed && iss < CNT_W'(K)) || (cmd.pass_run && iss < pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss <= '0;
      rd_seed <= 1'b0;
      rd_pass <= 1'b0;
    end else begin
      if (cmd.run_start || cmd.pass_init) begin
        iss <= '0;
      end else if (issuing) begin
        iss <= iss + CNT_W'(1);
      end
      rd_seed <= issuing && cmd.seed;
      rd_pass <= issuing && cmd.pass_run;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= iss;
  end

  // Point store: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      pmem[pc[IDX_W-1:0]] <= s_axis_tdata;
    end
    rd_pt <= pmem[iss[IDX_W-1:0]];
  end

  // Assignment store: write at pass writeback, registered read
  always_ff @(posedge clk) begin
    if (e_v) begin
      amem[e_idx] <= e_best;
    end
    rd_as <= amem[iss[IDX_W-1:0]];
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      a_v <= rd_pass;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
    end
  end

  // Distance pipeline payload
  always_ff @(posedge clk) begin
    a_idx <= rd_idx[IDX_W-1:0];
    a_px <= rd_pt[C-1:0];
    a_py <= rd_pt[2*C-1:C];
    a_old <= rd_as;
    for (int k = 0; k < K; k++) begin
      a_dx[k] <= (rd_pt[C-1:0] > cx[k]) ? rd_pt[C-1:0] - cx[k] : cx[k] - rd_pt[C-1:0];
      a_dy[k] <= (rd_pt[2*C-1:C] > cy[k]) ? rd_pt[2*C-1:C] - cy[k] : cy[k] - rd_pt[2*C-1:C];
    end
    b_idx <= a_idx;
    b_px <= a_px;
    b_py <= a_py;
    b_old <= a_old;
    for (int k = 0; k < K; k++) begin
      b_sx[k] <= a_dx[k] * a_dx[k];
      b_sy[k] <= a_dy[k] * a_dy[k];
    end
    c_idx <= b_idx;
    c_px <= b_px;
    c_py <= b_py;
    c_old <= b_old;
    for (int k = 0; k < K; k++) begin
      c_d[k] <= D_W'(b_sx[k]) + D_W'(b_sy[k]);
    end
    // Pairwise minimum; the lower index keeps ties
    d_idx <= c_idx;
    d_px <= c_px;
    d_py <= c_py;
    d_old <= c_old;
    d_w01 <= (c_d[1] < c_d[0]) ? CW'(1) : CW'(0);
    d_d01 <= (c_d[1] < c_d[0]) ? c_d[1] : c_d[0];
    d_w23 <= (c_d[3] < c_d[2]) ? CW'(3) : CW'(2);
    d_d23 <= (c_d[3] < c_d[2]) ? c_d[3] : c_d[2];
    e_idx <= d_idx;
    e_px <= d_px;
    e_py <= d_py;
    e_old <= d_old;
    e_best <= (d_d23 < d_d01) ? d_w23 : d_w01;
  end

  // One cluster read port shared by writeback, divider and output
  always_comb begin
    if (cmd.emit) begin
      cl_sel = oj;
    end else if (cmd.div_run) begin
      cl_sel = jb[CW:1];
    end else begin
      cl_sel = e_best;
    end
  end

  assign sel_cnt = cnt[cl_sel];
  assign sel_sx = sx[cl_sel];
  assign sel_sy = sy[cl_sel];

  // Divider step
  assign div_sum = jb[0] ? sel_sy : sel_sx;
  assign trial = {rem, q[C-1]};
  assign qbit = (trial >= {1'b0, sel_cnt});
  assign rem_next = qbit ? CNT_W'(trial - {1'b0, sel_cnt}) : trial[CNT_W-1:0];
  assign div_adv = cmd.div_run && ((bc == '0 && sel_cnt == '0) || bc == kmc_pkg::BC_W'(C));

  // Accumulators, change flag and centers
  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
      first_pass <= 1'b0;
      jb <= '0;
      bc <= '0;
      iters <= '0;
    end else begin
      if (cmd.run_start) begin
        first_pass <= 1'b1;
        iters <= '0;
      end
      if (cmd.pass_init) begin
        changed <= first_pass;
      end else if (e_v && e_best != e_old) begin
        changed <= 1'b1;
      end
      if (cmd.div_init) begin
        first_pass <= 1'b0;
        iters <= iters + kmc_pkg::ITER_W'(1);
        jb <= '0;
        bc <= '0;
      end else if (cmd.div_run) begin
        if (div_adv) begin
          jb <= jb + (CW+1)'(1);
          bc <= '0;
        end else begin
          bc <= bc + kmc_pkg::BC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      for (int k = 0; k < K; k++) begin
        cnt[k] <= '0;
        sx[k] <= '0;
        sy[k] <= '0;
      end
    end else if (e_v) begin
      cnt[e_best] <= sel_cnt + CNT_W'(1);
      sx[e_best] <= sel_sx + SUM_W'(e_px);
      sy[e_best] <= sel_sy + SUM_W'(e_py);
    end
    if (rd_seed) begin
      cx[rd_idx[CW-1:0]] <= rd_pt[C-1:0];
      cy[rd_idx[CW-1:0]] <= rd_pt[2*C-1:C];
    end
    // Shift one quotient bit per cycle; skip empty clusters
    if (cmd.div_run) begin
      if (bc == '0) begin
        rem <= CNT_W'(div_sum[SUM_W-1:C]);
        q <= div_sum[C-1:0];
      end else begin
        rem <= rem_next;
        q <= {q[C-2:0], qbit};
        if (bc == kmc_pkg::BC_W'(C)) begin
          if (jb[0]) begin
            cy[jb[CW:1]] <= {q[C-2:0], qbit};
          end else begin
            cx[jb[CW:1]] <= {q[C-2:0], qbit};
          end
        end
      end
    end
  end

  // Output register
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      oj <= '0;
    end else begin
      if (cmd.res_init) begin
        oj <= '0;
      end else if (cmd.emit && out_free) begin
        oj <= oj + CW'(1);
      end
      if (cmd.out_flag || (cmd.emit && out_free)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_flag) begin
      o_idx <= '0;
      o_cx <= '0;
      o_cy <= '0;
      o_size <= '0;
      o_iter <= '0;
      o_stat <= cmd.flag_code;
      o_last <= 1'b1;
    end else if (cmd.emit && out_free) begin
      o_idx <= oj;
      o_cx <= cx[oj];
      o_cy <= cy[oj];
      o_size <= kmc_pkg::SIZE_W'(sel_cnt);
      o_iter <= iters;
      o_stat <= changed ? kmc_pkg::STAT_LIMIT : kmc_pkg::STAT_CONVERGED;
      o_last <= (oj == CW'(K - 1));
    end
  end

  assign m_axis_tdata = {{kmc_pkg::OUT_PAD_W{1'b0}}, o_iter, o_size, o_cy, o_cx, o_idx};
  assign m_axis_tuser = o_stat;
  assign m_axis_tlast = o_last;

  // Status to the sequencer
  always_comb begin
    sts.out_busy = m_axis_tvalid;
    sts.full = (pc >= CNT_W'(MAX_POINTS));
    sts.few = (pc < CNT_W'(K));
    sts.seed_done = rd_seed && (rd_idx == CNT_W'(K - 1));
    sts.pass_done = cmd.pass_run && (iss == pc) && !(rd_pass || a_v || b_v || c_v || d_v || e_v);
    sts.changed = changed;
    sts.limit_hit = (iters >= limit);
    sts.div_done = div_adv && (jb == (CW+1)'(2 * K - 1));
    sts.res_done = cmd.emit && out_free && (oj == CW'(K - 1));
  end

endmodule

// ===== src/kmeans_2d_clustering.sv =====
// ----------------------------------------------------------------------------
// kmeans_2d_clustering
// Lloyd k-means over stored 2-D Q0.16 points with four clusters.
//
// channel   dir  meaning
// s_axis    in   tuser: action; tdata: point_x, point_y
// m_axis    out  tuser: status; tdata: cluster index, center, size, iterations
// cfg       in   write enable and data of the iteration limit
//
// Clear and load each complete with their input transfer; a full-store load or a short run gives
// one result. A run seeds the centers, then alternates assignment passes and
// center updates, then sends four result transfers: one point read per cycle
// in a pass and one quotient bit per cycle in an update; an empty cluster
// skips its division and keeps its center.
// Reset is synchronous; the stores need no clearing pass. Input stalls while
// a run is busy or a result waits.
// ----------------------------------------------------------------------------
module kmeans_2d_clustering #(
  parameter int MAX_POINTS = kmc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_x [15:0], point_y [31:16]
  input  logic [kmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  logic [kmc_pkg::ACT_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cluster_index [1:0], center_x [17:2], center_y [33:18],
  // cluster_size [44:34], iteration_count [60:45], zero fill [63:61]
  output logic [kmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [kmc_pkg::STAT_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_wr_en,
  input  logic [kmc_pkg::ITER_W-1:0]      cfg_wr_data
);

  kmc_pkg::cmd_t cmd;
  kmc_pkg::sts_t sts;

  kmc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts           (sts),
    .cmd           (cmd)
  );

  kmc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
